// File: hdl/rmlsa_pkg.sv
`default_nettype none
package rmlsa_pkg;

	localparam int NUM_REGS_DEF  = 16;
	localparam int MEM_WORDS_DEF = 256;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_ADD   = 2'd2;

	localparam logic [1:0] FORM_REG = 2'd0;
	localparam logic [1:0] FORM_IMM = 2'd1;
	localparam logic [1:0] FORM_MEM = 2'd2;

	localparam logic DST_REG = 1'b0;
	localparam logic DST_MEM = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_REG  = 3'd1,
		ST_BAD_ADDR = 3'd2,
		ST_BAD_FORM = 3'd3,
		ST_HALTED   = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               dst_mode;
		logic signed [31:0] dst_index;
		logic [1:0]         src1_mode;
		logic signed [31:0] src1_value;
		logic [1:0]         src2_mode;
		logic signed [31:0] src2_value;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] written_value;
	} result_t;

	// Classified instruction handed from the front to the execute side.
	typedef struct packed {
		status_t     status;
		logic [1:0]  src1_form;
		logic [31:0] src1_value;
		logic [1:0]  src2_form;
		logic [31:0] src2_value;
		logic        dst_mem;
		logic [31:0] dst_index;
	} plan_t;

endpackage
`default_nettype wire

// File: hdl/reg_mem_load_store_add_unit.sv
`default_nettype none
// Executes decoded load, store and add instructions on a register file of
// NUM_REGS words and a data memory of MEM_WORDS words. Requests enter a
// classify stage that does every range and form check and tracks the halt,
// then wait in a two-entry queue for the execute side. A good instruction
// goes there through a first operand read, a second operand read, and an add
// with writeback, in turn, as each storage array has a single port. A failing
// or halted one goes straight to the result queue. Results wait in a two-entry
// queue, so requests are still taken while results are not popped, until both
// queues fill. After reset the execute side clears both arrays, one word per
// cycle up to the larger of NUM_REGS and MEM_WORDS, with full high till done.
module reg_mem_load_store_add_unit
	import rmlsa_pkg::*;
#(
	parameter int NUM_REGS  = NUM_REGS_DEF,
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);

	logic    accept;
	logic    busy;
	logic    plan_full;
	logic    plan_empty;
	logic    plan_pop;
	plan_t   plan_in;
	plan_t   plan_head;
	logic    res_full;
	logic    res_push;
	result_t res_in;

	assign full   = plan_full || busy;
	assign accept = push && !full;

	rmlsa_front #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.plan   (plan_in)
	);

	rmlsa_fifo #(.WIDTH($bits(plan_t)), .DEPTH(QUEUE_DEPTH)) u_plan_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.full   (plan_full),
		.din    (plan_in),
		.pop    (plan_pop),
		.empty  (plan_empty),
		.dout   (plan_head)
	);

	rmlsa_back #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_empty (plan_empty),
		.plan       (plan_head),
		.plan_pop   (plan_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.result     (res_in),
		.busy       (busy)
	);

	rmlsa_fifo #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

	// The execute side reserves result room before it starts an instruction.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result pushed into a full queue");

	// No request may be taken while the arrays are still being cleared.
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> !accept && !plan_pop)
		else $error("request taken during the clearing sweep");

	// A failed or halted instruction never reports a written value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_OK) |-> (result.written_value == '0))
		else $error("nonzero value reported with an error status");

endmodule
`default_nettype wire

// File: hdl/rmlsa_ram.sv
`default_nettype none
module rmlsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/rmlsa_fifo.sv
`default_nettype none
module rmlsa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

// File: hdl/rmlsa_front.sv
`default_nettype none
module rmlsa_front
	import rmlsa_pkg::*;
#(
	parameter int NUM_REGS  = NUM_REGS_DEF,
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire item_t item,
	output plan_t      plan
);

	logic halted_q;

	// A negative index has bit 31 set, so the unsigned compare rejects it.
	function automatic logic reg_ok(input logic [31:0] v);
		return v < 32'(NUM_REGS);
	endfunction

	function automatic logic mem_ok(input logic [31:0] v);
		return v < 32'(MEM_WORDS);
	endfunction

	function automatic status_t fetch_status(input logic [1:0] mode, input logic [31:0] v);
		status_t s;
		case (mode)
			FORM_REG: s = reg_ok(v) ? ST_OK : ST_BAD_REG;
			FORM_IMM: s = ST_OK;
			FORM_MEM: s = mem_ok(v) ? ST_OK : ST_BAD_ADDR;
			default:  s = ST_BAD_FORM;
		endcase
		return s;
	endfunction

	status_t s1;
	status_t s2;

	always_comb begin
		s1              = fetch_status(item.src1_mode, item.src1_value);
		s2              = fetch_status(item.src2_mode, item.src2_value);
		plan.status     = ST_OK;
		plan.src1_form  = item.src1_mode;
		plan.src1_value = item.src1_value;
		plan.src2_form  = FORM_IMM;
		plan.src2_value = '0;
		plan.dst_mem    = DST_REG;
		plan.dst_index  = item.dst_index;
		case (item.kind)
			KIND_LOAD: begin
				if (!reg_ok(item.dst_index)) begin
					plan.status = ST_BAD_REG;
				end else if (item.src1_mode != FORM_IMM && item.src1_mode != FORM_MEM) begin
					plan.status = ST_BAD_FORM;
				end else begin
					plan.status = s1;
				end
			end
			KIND_STORE: begin
				plan.dst_mem = DST_MEM;
				if (!mem_ok(item.dst_index)) begin
					plan.status = ST_BAD_ADDR;
				end else if (item.src1_mode != FORM_IMM && item.src1_mode != FORM_REG) begin
					plan.status = ST_BAD_FORM;
				end else begin
					plan.status = s1;
				end
			end
			KIND_ADD: begin
				plan.src2_form  = item.src2_mode;
				plan.src2_value = item.src2_value;
				plan.dst_mem    = item.dst_mode;
				if (s1 != ST_OK) begin
					plan.status = s1;
				end else if (s2 != ST_OK) begin
					plan.status = s2;
				end else if (item.dst_mode == DST_REG && !reg_ok(item.dst_index)) begin
					plan.status = ST_BAD_REG;
				end else if (item.dst_mode == DST_MEM && !mem_ok(item.dst_index)) begin
					plan.status = ST_BAD_ADDR;
				end
			end
			default: begin
				plan.status = ST_BAD_FORM;
			end
		endcase
		if (halted_q) begin
			plan.status = ST_HALTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (accept && plan.status != ST_OK) begin
			halted_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hdl/rmlsa_back.sv
`default_nettype none
module rmlsa_back
	import rmlsa_pkg::*;
#(
	parameter int NUM_REGS  = NUM_REGS_DEF,
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  plan_empty,
	input  wire plan_t plan,
	output logic       plan_pop,
	input  wire logic  res_full,
	output logic       res_push,
	output result_t    result,
	output logic       busy
);

	localparam int RIW   = $clog2(NUM_REGS);
	localparam int AW    = $clog2(MEM_WORDS);
	localparam int CLR_N = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
	localparam int CLW   = $clog2(CLR_N);

	typedef enum logic [3:0] {
		BK_CLEAR = 4'b0001,
		BK_IDLE  = 4'b0010,
		BK_READ2 = 4'b0100,
		BK_WRITE = 4'b1000
	} back_state_t;

	back_state_t state_q;
	logic [CLW-1:0] clr_cnt_q;
	plan_t          plan_q;
	logic [31:0]    a_q;
	logic [31:0]    op_a;
	logic [31:0]    op_b;
	logic           start;

	logic           reg_we;
	logic           reg_re;
	logic [RIW-1:0] reg_addr;
	logic [31:0]    reg_wdata;
	logic [31:0]    reg_rdata;
	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_addr;
	logic [31:0]    mem_wdata;
	logic [31:0]    mem_rdata;

	rmlsa_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_regs (
		.clk   (clk),
		.we    (reg_we),
		.re    (reg_re),
		.addr  (reg_addr),
		.wdata (reg_wdata),
		.rdata (reg_rdata)
	);

	rmlsa_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Each read returns in the cycle after it is issued, and the RAMs hold their
	// read data until the next read on the same port.
	always_comb begin
		case (plan_q.src1_form)
			FORM_REG: op_a = reg_rdata;
			FORM_MEM: op_a = mem_rdata;
			default:  op_a = plan_q.src1_value;
		endcase
		case (plan_q.src2_form)
			FORM_REG: op_b = reg_rdata;
			FORM_MEM: op_b = mem_rdata;
			default:  op_b = plan_q.src2_value;
		endcase
	end

	// Only this side pushes into the result queue, so room seen
	// at the start is still there at writeback.
	assign start    = (state_q == BK_IDLE) && !plan_empty && !res_full;
	assign plan_pop = start;
	assign busy     = (state_q == BK_CLEAR);

	always_comb begin
		reg_we               = 1'b0;
		reg_re               = 1'b0;
		reg_addr             = '0;
		reg_wdata            = '0;
		mem_we               = 1'b0;
		mem_re               = 1'b0;
		mem_addr             = '0;
		mem_wdata            = '0;
		res_push             = 1'b0;
		result.status        = ST_OK;
		result.written_value = '0;
		case (state_q)
			BK_CLEAR: begin
				reg_we   = 32'(clr_cnt_q) < NUM_REGS;
				reg_addr = clr_cnt_q[RIW-1:0];
				mem_we   = 32'(clr_cnt_q) < MEM_WORDS;
				mem_addr = clr_cnt_q[AW-1:0];
			end
			BK_IDLE: begin
				if (start) begin
					if (plan.status != ST_OK) begin
						res_push      = 1'b1;
						result.status = plan.status;
					end else if (plan.src1_form == FORM_REG) begin
						reg_re   = 1'b1;
						reg_addr = plan.src1_value[RIW-1:0];
					end else if (plan.src1_form == FORM_MEM) begin
						mem_re   = 1'b1;
						mem_addr = plan.src1_value[AW-1:0];
					end
				end
			end
			BK_READ2: begin
				if (plan_q.src2_form == FORM_REG) begin
					reg_re   = 1'b1;
					reg_addr = plan_q.src2_value[RIW-1:0];
				end else if (plan_q.src2_form == FORM_MEM) begin
					mem_re   = 1'b1;
					mem_addr = plan_q.src2_value[AW-1:0];
				end
			end
			BK_WRITE: begin
				res_push             = 1'b1;
				result.written_value = a_q + op_b;
				if (plan_q.dst_mem == DST_MEM) begin
					mem_we    = 1'b1;
					mem_addr  = plan_q.dst_index[AW-1:0];
					mem_wdata = a_q + op_b;
				end else begin
					reg_we    = 1'b1;
					reg_addr  = plan_q.dst_index[RIW-1:0];
					reg_wdata = a_q + op_b;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			case (state_q)
				BK_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CLW'(CLR_N - 1)) begin
						state_q <= BK_IDLE;
					end
				end
				BK_IDLE: begin
					if (start && plan.status == ST_OK) begin
						state_q <= BK_READ2;
					end
				end
				BK_READ2: state_q <= BK_WRITE;
				BK_WRITE: state_q <= BK_IDLE;
				default:  state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			plan_q <= plan;
		end
		if (state_q == BK_READ2) begin
			a_q <= op_a;
		end
	end

endmodule
`default_nettype wire
